FILE: sv/record_stack_with_key_scan_unit_defines.svh
// Assertion macros shared by the record stack files.
`ifndef RECORD_STACK_WITH_KEY_SCAN_UNIT_DEFINES_SVH
`define RECORD_STACK_WITH_KEY_SCAN_UNIT_DEFINES_SVH

// The condition holds at every clock edge outside reset.
`define RSKS_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// The consequence holds in the same cycle as the trigger.
`define RSKS_ASSERT_IMPLY(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cons)) \
        else $error(msg);

// The consequence holds in the cycle after the trigger.
`define RSKS_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/rsks_pkg.sv
// Operation and status codes for the record stack with key scan.
package rsks_pkg;

    localparam int LABEL_BITS = 64;

    localparam logic [1:0] KIND_PUSH = 2'd0;
    localparam logic [1:0] KIND_POP  = 2'd1;
    localparam logic [1:0] KIND_FIND = 2'd2;

    localparam logic [2:0] ST_PUSHED = 3'd0;
    localparam logic [2:0] ST_FULL   = 3'd1;
    localparam logic [2:0] ST_POPPED = 3'd2;
    localparam logic [2:0] ST_EMPTY  = 3'd3;
    localparam logic [2:0] ST_MATCH  = 3'd4;
    localparam logic [2:0] ST_NONE   = 3'd5;

endpackage

FILE: sv/rsks_store.sv
// Record memory: one write port and one registered read port.
module rsks_store
    import rsks_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int WIDTH      = 88,
    parameter int ADDR_BITS  = 6
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read data holds while no read is issued, so the scan can wait on a stall.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/record_stack_with_key_scan_unit.sv
// Top level of the record stack: push, pop and find by age over a LIFO memory.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------
//  in      | i_in_valid / o_in_stall  | i_kind, i_age, i_label, i_size
//  out     | o_out_valid / i_out_stall| o_status, o_rec_age, o_rec_label, o_rec_size,
//          |                        | o_no_match, o_last
//
// Pushes, full or not, and empty pops answer from S_IDLE; pops answer from S_POP.
// A find reads one entry a cycle through the single read port and one age comparator,
// from the top of the stack down, except while a second match waits on an output stall.
// An unused kind is accepted but gives no output word.
// Reset empties the stack; entry contents are not cleared.
// An output stall holds the scan only when a second match must be sent; the input is
// stalled while an item is at work and while a finished word waits on an output stall.

`include "record_stack_with_key_scan_unit_defines.svh"

module record_stack_with_key_scan_unit
    import rsks_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int AGE_BITS    = 8,
    parameter int SIZE_BITS   = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_kind,
    input  logic [AGE_BITS-1:0]   i_age,
    input  logic [LABEL_BITS-1:0] i_label,
    input  logic [SIZE_BITS-1:0]  i_size,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [2:0]            o_status,
    output logic [AGE_BITS-1:0]   o_rec_age,
    output logic [LABEL_BITS-1:0] o_rec_label,
    output logic [SIZE_BITS-1:0]  o_rec_size,
    output logic                  o_no_match,
    output logic                  o_last
);

    localparam int ADDR_BITS = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(STACK_DEPTH + 1);
    localparam int REC_BITS  = AGE_BITS + LABEL_BITS + SIZE_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                r_state;
    logic [CNT_BITS-1:0]   r_fill;
    logic [CNT_BITS-1:0]   r_left;
    logic [ADDR_BITS-1:0]  r_idx;
    logic                  r_have;
    logic [AGE_BITS-1:0]   r_key;
    logic                  r_pend_valid;
    logic [REC_BITS-1:0]   r_pend;

    logic                  r_out_valid;
    logic [2:0]            r_status;
    logic [AGE_BITS-1:0]   r_rec_age;
    logic [LABEL_BITS-1:0] r_rec_label;
    logic [SIZE_BITS-1:0]  r_rec_size;
    logic                  r_no_match;
    logic                  r_last;

    logic                  out_free;
    logic                  in_acc;
    logic                  full;
    logic                  empty;
    logic [CNT_BITS-1:0]   fill_dec;
    logic [REC_BITS-1:0]   rdata;
    logic [AGE_BITS-1:0]   rd_age;
    logic                  hit;
    logic                  emit_blk;
    logic                  mem_we;
    logic                  mem_re;
    logic [ADDR_BITS-1:0]  mem_raddr;

    always_comb begin
        out_free  = !r_out_valid || !i_out_stall;
        in_acc    = i_in_valid && (r_state == S_IDLE) && out_free;
        full      = (r_fill >= CNT_BITS'(STACK_DEPTH));
        empty     = (r_fill == '0);
        fill_dec  = r_fill - CNT_BITS'(1);
        rd_age    = rdata[REC_BITS-1 -: AGE_BITS];
        hit       = r_have && (rd_age == r_key);
        // A second match can only retire the held one when the output word is free.
        emit_blk  = hit && r_pend_valid && !out_free;
        mem_we    = in_acc && (i_kind == KIND_PUSH) && !full;
        mem_re    = 1'b0;
        mem_raddr = r_idx;
        if (in_acc && (i_kind == KIND_POP) && !empty) begin
            mem_re    = 1'b1;
            mem_raddr = fill_dec[ADDR_BITS-1:0];
        end else if ((r_state == S_SCAN) && !emit_blk && (r_left != '0)) begin
            mem_re    = 1'b1;
        end
    end

    rsks_store #(
        .DEPTH     (STACK_DEPTH),
        .WIDTH     (REC_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_fill[ADDR_BITS-1:0]),
        .i_wdata ({i_age, i_label, i_size}),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fill       <= '0;
            r_left       <= '0;
            r_have       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_kind)
                            KIND_PUSH: begin
                                r_out_valid <= 1'b1;
                                r_status    <= full ? ST_FULL : ST_PUSHED;
                                r_rec_age   <= '0;
                                r_rec_label <= '0;
                                r_rec_size  <= '0;
                                r_no_match  <= 1'b0;
                                r_last      <= 1'b1;
                                if (!full) begin
                                    r_fill <= r_fill + CNT_BITS'(1);
                                end
                            end
                            KIND_POP: begin
                                if (empty) begin
                                    r_out_valid <= 1'b1;
                                    r_status    <= ST_EMPTY;
                                    r_rec_age   <= '0;
                                    r_rec_label <= '0;
                                    r_rec_size  <= '0;
                                    r_no_match  <= 1'b0;
                                    r_last      <= 1'b1;
                                end else begin
                                    r_fill  <= fill_dec;
                                    r_state <= S_POP;
                                end
                            end
                            KIND_FIND: begin
                                r_key        <= i_age;
                                r_left       <= r_fill;
                                r_idx        <= fill_dec[ADDR_BITS-1:0];
                                r_have       <= 1'b0;
                                r_pend_valid <= 1'b0;
                                r_state      <= S_SCAN;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_POP: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_status    <= ST_POPPED;
                        r_rec_age   <= rdata[REC_BITS-1 -: AGE_BITS];
                        r_rec_label <= rdata[SIZE_BITS +: LABEL_BITS];
                        r_rec_size  <= rdata[SIZE_BITS-1:0];
                        r_no_match  <= 1'b0;
                        r_last      <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_SCAN: begin
                    if (!emit_blk) begin
                        // The newest match is held back until it is known whether it is last.
                        if (hit) begin
                            if (r_pend_valid) begin
                                r_out_valid <= 1'b1;
                                r_status    <= ST_MATCH;
                                r_rec_age   <= r_pend[REC_BITS-1 -: AGE_BITS];
                                r_rec_label <= r_pend[SIZE_BITS +: LABEL_BITS];
                                r_rec_size  <= r_pend[SIZE_BITS-1:0];
                                r_no_match  <= 1'b0;
                                r_last      <= 1'b0;
                            end
                            r_pend       <= rdata;
                            r_pend_valid <= 1'b1;
                        end
                        r_have <= (r_left != '0);
                        if (r_left != '0) begin
                            r_left <= r_left - CNT_BITS'(1);
                            r_idx  <= r_idx - ADDR_BITS'(1);
                        end else if (!r_have) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_last      <= 1'b1;
                        if (r_pend_valid) begin
                            r_status    <= ST_MATCH;
                            r_rec_age   <= r_pend[REC_BITS-1 -: AGE_BITS];
                            r_rec_label <= r_pend[SIZE_BITS +: LABEL_BITS];
                            r_rec_size  <= r_pend[SIZE_BITS-1:0];
                            r_no_match  <= 1'b0;
                        end else begin
                            r_status    <= ST_NONE;
                            r_rec_age   <= '0;
                            r_rec_label <= '0;
                            r_rec_size  <= '0;
                            r_no_match  <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = !((r_state == S_IDLE) && out_free);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_rec_age   = r_rec_age;
    assign o_rec_label = r_rec_label;
    assign o_rec_size  = r_rec_size;
    assign o_no_match  = r_no_match;
    assign o_last      = r_last;

    `RSKS_ASSERT_ALWAYS(a_fill_bound, r_fill <= CNT_BITS'(STACK_DEPTH),
        "fill count above depth")
    `RSKS_ASSERT_IMPLY(a_none_is_last, o_out_valid && o_no_match,
        o_last && (o_status == ST_NONE), "no-match word malformed")
    `RSKS_ASSERT_NEXT(a_push_grows, in_acc && (i_kind == KIND_PUSH) && !full,
        r_fill == $past(r_fill) + CNT_BITS'(1), "push did not grow the stack")

endmodule
